>>> hdl/mgr_pkg.sv
package mgr_pkg;

    // single-precision constants
    localparam logic [31:0] F_ZERO     = 32'h0000_0000;
    localparam logic [31:0] F_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F_NEG_ONE  = 32'hBF80_0000;
    localparam logic [31:0] F_GAM      = 32'h4580_0000;  // 4096
    localparam logic [31:0] F_RGAM     = 32'h3980_0000;  // 1/4096
    localparam logic [31:0] F_GAM_SQ   = 32'h4B80_0000;  // 4096*4096
    localparam logic [31:0] F_RGAM_SQ  = 32'h3380_0000;  // 1/(4096*4096)
    localparam logic [31:0] F_HI_LIM   = 32'h4B7F_FFF0;  // 1.67772e7 rounded
    localparam logic [31:0] F_LO_LIM   = 32'h337F_FFF3;  // 5.96046e-8 rounded
    localparam logic [31:0] F_DNAN     = 32'hFFC0_0000;
    localparam logic [31:0] F_QBIT     = 32'h0040_0000;
    localparam logic [30:0] F_INF_MAG  = 31'h7F80_0000;

    localparam int MW        = 52;   // working mantissa width of the float unit
    localparam int DIV_STEPS = 27;   // quotient bits per division
    localparam int PASS_MAX  = 8;    // rescale passes per loop

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV
    } t_fop;

    typedef enum logic [1:0] {
        FLAG_IDENT = 2'd0,
        FLAG_FULL  = 2'd1,
        FLAG_OFF   = 2'd2,
        FLAG_DIAG  = 2'd3
    } t_flag;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_NORM,
        FS_RND
    } t_fpu_state;

    typedef enum logic [4:0] {
        ST_IDLE, ST_P2, ST_P2CHK, ST_P1, ST_Q2, ST_Q1, ST_BR,
        ST_H21, ST_H12, ST_OT, ST_OSU, ST_SUCHK, ST_OD_D1, ST_OD_D2, ST_OD_X1,
        ST_H11, ST_H22, ST_DT, ST_DSU, ST_DG_T, ST_DG_D2, ST_DG_X1,
        ST_R1_CHK, ST_R1_D, ST_R1_X, ST_R1_H11, ST_R1_H12,
        ST_R2_CHK, ST_R2_D, ST_R2_H21, ST_R2_H22, ST_DONE
    } t_seq_state;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_fpu_rsp;

    function automatic logic f_is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] f_mag(input logic [31:0] v);
        return {1'b0, v[30:0]};
    endfunction

    // ordered compares: false when either side is NaN, zeros of both signs equal
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic both_zero;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (f_is_nan(a) || f_is_nan(b) || both_zero) begin
            return 1'b0;
        end
        if (a[31] != b[31]) begin
            return a[31];
        end
        if (!a[31]) begin
            return a[30:0] < b[30:0];
        end
        return a[30:0] > b[30:0];
    endfunction

    function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
        if (f_is_nan(a) || f_is_nan(b)) begin
            return 1'b0;
        end
        return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    endfunction

    function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
        return f_lt(a, b) || f_eq(a, b);
    endfunction

endpackage

>>> hdl/mgr_fpu.sv
module mgr_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mgr_pkg::t_fpu_req  i_req,
    output mgr_pkg::t_fpu_rsp  o_rsp
);
    import mgr_pkg::*;

    t_fpu_state r_state, n_state;

    logic              r_done;
    logic [31:0]       r_res;
    logic              r_s;
    logic signed [11:0] r_e;
    logic [MW-1:0]     r_m;
    logic signed [11:0] r_sh;
    logic [25:0]       r_rem;
    logic [23:0]       r_div;
    logic [26:0]       r_q;
    logic [4:0]        r_cnt;

    logic ctl_load, ctl_step, ctl_norm, ctl_rnd;

    // ---------------- operand unpack and special values ----------------
    logic        sa, sb, sbe;
    logic [7:0]  fa, fb, ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec;
    logic [31:0] sres;

    // add path
    logic        a_big;
    logic [7:0]  e_big, e_sml, ediff;
    logic [23:0] m_big, m_sml;
    logic        s_big;
    logic [MW-1:0] w_big, w_sml, w_mask, w_al, w_sum;
    logic        w_stk;
    // mul path
    logic [47:0] m_prod;
    // div path
    logic [4:0]  lza, lzb;
    logic [23:0] man, mbn;

    logic        ld_s;
    logic signed [11:0] ld_e;
    logic [MW-1:0] ld_m;

    always_comb begin
        sa     = i_req.a[31];
        sb     = i_req.b[31];
        sbe    = sb ^ (i_req.op == FOP_SUB);
        fa     = i_req.a[30:23];
        fb     = i_req.b[30:23];
        ea     = (fa == 8'd0) ? 8'd1 : fa;
        eb     = (fb == 8'd0) ? 8'd1 : fb;
        ma     = {fa != 8'd0, i_req.a[22:0]};
        mb     = {fb != 8'd0, i_req.b[22:0]};
        a_nan  = f_is_nan(i_req.a);
        b_nan  = f_is_nan(i_req.b);
        a_inf  = (i_req.a[30:0] == F_INF_MAG);
        b_inf  = (i_req.b[30:0] == F_INF_MAG);
        a_zero = (i_req.a[30:0] == 31'd0);
        b_zero = (i_req.b[30:0] == 31'd0);

        spec = 1'b1;
        sres = F_DNAN;
        if (a_nan) begin
            sres = i_req.a | F_QBIT;
        end else if (b_nan) begin
            sres = i_req.b | F_QBIT;
        end else begin
            case (i_req.op)
                FOP_ADD, FOP_SUB: begin
                    if (a_inf && b_inf && (sa != sbe)) begin
                        sres = F_DNAN;
                    end else if (a_inf) begin
                        sres = {sa, F_INF_MAG};
                    end else if (b_inf) begin
                        sres = {sbe, F_INF_MAG};
                    end else begin
                        spec = 1'b0;
                    end
                end
                FOP_MUL: begin
                    if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                        sres = F_DNAN;
                    end else if (a_inf || b_inf) begin
                        sres = {sa ^ sb, F_INF_MAG};
                    end else if (a_zero || b_zero) begin
                        sres = {sa ^ sb, 31'd0};
                    end else begin
                        spec = 1'b0;
                    end
                end
                default: begin
                    if ((a_zero && b_zero) || (a_inf && b_inf)) begin
                        sres = F_DNAN;
                    end else if (a_inf || b_zero) begin
                        sres = {sa ^ sb, F_INF_MAG};
                    end else if (a_zero || b_inf) begin
                        sres = {sa ^ sb, 31'd0};
                    end else begin
                        spec = 1'b0;
                    end
                end
            endcase
        end

        // align the smaller addend against the larger one, sticky into the lsb
        a_big  = {ea, ma} >= {eb, mb};
        e_big  = a_big ? ea : eb;
        e_sml  = a_big ? eb : ea;
        m_big  = a_big ? ma : mb;
        m_sml  = a_big ? mb : ma;
        s_big  = a_big ? sa : sbe;
        ediff  = e_big - e_sml;
        w_big  = {1'b0, m_big, 27'd0};
        w_sml  = {1'b0, m_sml, 27'd0};
        w_mask = ~({MW{1'b1}} << ediff);
        w_stk  = |(w_sml & w_mask);
        w_al   = (w_sml >> ediff) | {{(MW-1){1'b0}}, w_stk};
        w_sum  = (sa != sbe) ? (w_big - w_al) : (w_big + w_al);

        // full-width significand product
        m_prod = ma * mb;

        // bring subnormal divide operands to a leading one
        lza = 5'd0;
        lzb = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (ma[i]) lza = 5'(23 - i);
            if (mb[i]) lzb = 5'(23 - i);
        end
        man = ma << lza;
        mbn = mb << lzb;

        case (i_req.op)
            FOP_MUL: begin
                ld_s = sa ^ sb;
                ld_e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd300;
                ld_m = {4'd0, m_prod};
            end
            FOP_DIV: begin
                ld_s = sa ^ sb;
                ld_e = $signed({4'd0, ea}) - $signed({7'd0, lza})
                     - $signed({4'd0, eb}) + $signed({7'd0, lzb}) - 12'sd26;
                ld_m = w_sum;
            end
            default: begin
                ld_s = (w_sum == '0) ? (sa & sbe) : s_big;
                ld_e = $signed({4'd0, e_big}) - 12'sd177;
                ld_m = w_sum;
            end
        endcase
    end

    // ---------------- normalize: leading one and shift amount ----------------
    logic [5:0]         lead;
    logic signed [11:0] sh_a, sh_b, sh_n;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < MW; i++) begin
            if (r_m[i]) lead = 6'(i);
        end
        sh_a = $signed({6'd0, lead}) - 12'sd23;
        sh_b = -12'sd149 - r_e;
        sh_n = (sh_a > sh_b) ? sh_a : sh_b;
    end

    // ---------------- round to nearest even and pack ----------------
    logic [6:0]         ramt;
    logic [4:0]         lamt;
    logic signed [11:0] neg_sh, fe, fe2;
    logic [MW+1:0]      wide, shr, lmask;
    logic [MW-1:0]      rm;
    logic               g, st, up, normal;
    logic [24:0]        r25;
    logic [22:0]        frac;
    logic [31:0]        rnd_res;

    always_comb begin
        wide   = {r_m, 2'b00};
        neg_sh = -r_sh;
        ramt   = (r_sh > 12'sd54) ? 7'd54 : r_sh[6:0];
        lamt   = neg_sh[4:0];
        shr    = wide >> ramt;
        lmask  = ~({(MW+2){1'b1}} << ramt);
        if (r_sh > 12'sd0) begin
            rm = shr[MW+1:2];
            g  = shr[1];
            st = shr[0] | (|(wide & lmask));
        end else begin
            rm = r_m << lamt;
            g  = 1'b0;
            st = 1'b0;
        end
        up  = g & (st | rm[0]);
        r25 = {1'b0, rm[23:0]} + {24'd0, up};
        fe  = r_e + r_sh + 12'sd150;
        if (r25[24]) begin
            fe2    = fe + 12'sd1;
            frac   = r25[23:1];
            normal = 1'b1;
        end else begin
            fe2    = fe;
            frac   = r25[22:0];
            normal = r25[23];
        end
        if (!normal) begin
            rnd_res = {r_s, 8'd0, frac};
        end else if (fe2 >= 12'sd255) begin
            rnd_res = {r_s, F_INF_MAG};
        end else begin
            rnd_res = {r_s, fe2[7:0], frac};
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_req.start && !spec) begin
                    n_state = (i_req.op == FOP_DIV) ? FS_DIV : FS_NORM;
                end
            end
            FS_DIV:  if (r_cnt == 5'd1) n_state = FS_NORM;
            FS_NORM: n_state = (r_m == '0) ? FS_IDLE : FS_RND;
            FS_RND:  n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        ctl_load = (r_state == FS_IDLE) && i_req.start;
        ctl_step = (r_state == FS_DIV);
        ctl_norm = (r_state == FS_NORM);
        ctl_rnd  = (r_state == FS_RND);
    end

    logic [25:0] rem_sub;
    logic        q_bit;
    assign q_bit   = r_rem >= {2'b00, r_div};
    assign rem_sub = q_bit ? (r_rem - {2'b00, r_div}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (ctl_load && spec) || ctl_rnd || (ctl_norm && (r_m == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_load) begin
            r_res <= sres;
            r_s   <= ld_s;
            r_e   <= ld_e;
            r_m   <= ld_m;
            r_rem <= {2'b00, man};
            r_div <= mbn;
            r_q   <= '0;
            r_cnt <= 5'(DIV_STEPS);
        end
        if (ctl_step) begin
            r_q   <= {r_q[25:0], q_bit};
            r_rem <= {rem_sub[24:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_m <= {{(MW-27){1'b0}}, r_q[25:0], q_bit | (rem_sub != 26'd0)};
            end
        end
        if (ctl_norm) begin
            r_sh  <= sh_n;
            r_res <= {r_s, 31'd0};
        end
        if (ctl_rnd) begin
            r_res <= rnd_res;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

>>> hdl/modified_givens_rotation_setup_unit.sv
// Result path: off-diagonal or diagonal, each followed by up to PASS_MAX d1 rescale passes and
//   up to PASS_MAX d2 passes; negative d1, zero d2*y1 and q2 < 0 end the beat early.
// A new beat is not taken while one is in flight; the next start is taken the cycle after the result.
// Shared float unit: one mgr_fpu serves every operation; divide runs its quotient steps before
//   normalize and round, add and multiply go straight to them, special operands answer at load.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops any beat.
module modified_givens_rotation_setup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_scale_one,
    input  logic [31:0] i_scale_two,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    output logic        o_valid,
    output logic [1:0]  o_flag_code,
    output logic [31:0] o_h_one_one,
    output logic [31:0] o_h_two_one,
    output logic [31:0] o_h_one_two,
    output logic [31:0] o_h_two_two,
    output logic [31:0] o_new_scale_one,
    output logic [31:0] o_new_scale_two,
    output logic [31:0] o_new_coord_x
);
    import mgr_pkg::*;

    t_seq_state r_state, n_state;

    // working set of the rotation
    logic [31:0] r_d1, r_d2, r_x1, r_y1;
    logic [31:0] r_h11, r_h21, r_h12, r_h22;
    logic [31:0] r_p1, r_p2, r_q1, r_q2, r_su;
    t_flag       r_flag;
    logic [3:0]  r_n;     // rescale pass counter
    logic        r_up;    // scale up (value too small) or down
    logic        r_wait;  // operation issued, waiting on the float unit

    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;
    logic        is_op;
    logic        done;

    mgr_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    assign done = fpu_rsp.done && r_wait;

    // rescale loop conditions; NaN fails every ordered compare and drops out
    logic r1_go, r2_go, r1_up, r2_up;
    always_comb begin
        r1_up = f_le(r_d1, F_LO_LIM);
        r2_up = f_le(f_mag(r_d2), F_LO_LIM);
        r1_go = !f_eq(r_d1, F_ZERO) && (r_n < 4'(PASS_MAX))
              && (r1_up || f_le(F_HI_LIM, r_d1));
        r2_go = !f_eq(r_d2, F_ZERO) && (r_n < 4'(PASS_MAX))
              && (r2_up || f_le(F_HI_LIM, f_mag(r_d2)));
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = f_lt(i_scale_one, F_ZERO) ? ST_DONE : ST_P2;
                end
            end
            ST_P2:    if (done) n_state = ST_P2CHK;
            ST_P2CHK: n_state = f_eq(r_p2, F_ZERO) ? ST_DONE : ST_P1;
            ST_P1:    if (done) n_state = ST_Q2;
            ST_Q2:    if (done) n_state = ST_Q1;
            ST_Q1:    if (done) n_state = ST_BR;
            ST_BR: begin
                if (f_lt(f_mag(r_q2), f_mag(r_q1))) begin
                    n_state = ST_H21;
                end else if (f_lt(r_q2, F_ZERO)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_H11;
                end
            end
            ST_H21:    if (done) n_state = ST_H12;
            ST_H12:    if (done) n_state = ST_OT;
            ST_OT:     if (done) n_state = ST_OSU;
            ST_OSU:    if (done) n_state = ST_SUCHK;
            ST_SUCHK:  n_state = f_lt(F_ZERO, r_su) ? ST_OD_D1 : ST_DONE;
            ST_OD_D1:  if (done) n_state = ST_OD_D2;
            ST_OD_D2:  if (done) n_state = ST_OD_X1;
            ST_OD_X1:  if (done) n_state = ST_R1_CHK;
            ST_H11:    if (done) n_state = ST_H22;
            ST_H22:    if (done) n_state = ST_DT;
            ST_DT:     if (done) n_state = ST_DSU;
            ST_DSU:    if (done) n_state = ST_DG_T;
            ST_DG_T:   if (done) n_state = ST_DG_D2;
            ST_DG_D2:  if (done) n_state = ST_DG_X1;
            ST_DG_X1:  if (done) n_state = ST_R1_CHK;
            ST_R1_CHK: n_state = r1_go ? ST_R1_D : ST_R2_CHK;
            ST_R1_D:   if (done) n_state = ST_R1_X;
            ST_R1_X:   if (done) n_state = ST_R1_H11;
            ST_R1_H11: if (done) n_state = ST_R1_H12;
            ST_R1_H12: if (done) n_state = ST_R1_CHK;
            ST_R2_CHK: n_state = r2_go ? ST_R2_D : ST_DONE;
            ST_R2_D:   if (done) n_state = ST_R2_H21;
            ST_R2_H21: if (done) n_state = ST_R2_H22;
            ST_R2_H22: if (done) n_state = ST_R2_CHK;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- operation select for the shared float unit ----------------
    logic [31:0] big_k, small_k;
    assign big_k   = r_up ? F_GAM_SQ : F_RGAM_SQ;  // scale for d
    assign small_k = r_up ? F_RGAM : F_GAM;        // matching scale for x1 and H

    always_comb begin
        is_op     = 1'b1;
        fpu_req.op = FOP_MUL;
        fpu_req.a  = r_d2;
        fpu_req.b  = r_y1;
        case (r_state)
            ST_P2:     begin fpu_req.a = r_d2;  fpu_req.b = r_y1; end
            ST_P1:     begin fpu_req.a = r_d1;  fpu_req.b = r_x1; end
            ST_Q2:     begin fpu_req.a = r_p2;  fpu_req.b = r_y1; end
            ST_Q1:     begin fpu_req.a = r_p1;  fpu_req.b = r_x1; end
            ST_H21: begin
                fpu_req.op = FOP_DIV;
                fpu_req.a  = {~r_y1[31], r_y1[30:0]};
                fpu_req.b  = r_x1;
            end
            ST_H12:    begin fpu_req.op = FOP_DIV; fpu_req.a = r_p2; fpu_req.b = r_p1; end
            ST_OT:     begin fpu_req.a = r_h12; fpu_req.b = r_h21; end
            ST_OSU:    begin fpu_req.op = FOP_SUB; fpu_req.a = F_ONE; fpu_req.b = r_su; end
            ST_OD_D1:  begin fpu_req.op = FOP_DIV; fpu_req.a = r_d1; fpu_req.b = r_su; end
            ST_OD_D2:  begin fpu_req.op = FOP_DIV; fpu_req.a = r_d2; fpu_req.b = r_su; end
            ST_OD_X1:  begin fpu_req.a = r_x1;  fpu_req.b = r_su; end
            ST_H11:    begin fpu_req.op = FOP_DIV; fpu_req.a = r_p1; fpu_req.b = r_p2; end
            ST_H22:    begin fpu_req.op = FOP_DIV; fpu_req.a = r_x1; fpu_req.b = r_y1; end
            ST_DT:     begin fpu_req.a = r_h11; fpu_req.b = r_h22; end
            ST_DSU:    begin fpu_req.op = FOP_ADD; fpu_req.a = F_ONE; fpu_req.b = r_su; end
            ST_DG_T:   begin fpu_req.op = FOP_DIV; fpu_req.a = r_d2; fpu_req.b = r_su; end
            ST_DG_D2:  begin fpu_req.op = FOP_DIV; fpu_req.a = r_d1; fpu_req.b = r_su; end
            ST_DG_X1:  begin fpu_req.a = r_y1;  fpu_req.b = r_su; end
            ST_R1_D:   begin fpu_req.a = r_d1;  fpu_req.b = big_k; end
            ST_R1_X:   begin fpu_req.a = r_x1;  fpu_req.b = small_k; end
            ST_R1_H11: begin fpu_req.a = r_h11; fpu_req.b = small_k; end
            ST_R1_H12: begin fpu_req.a = r_h12; fpu_req.b = small_k; end
            ST_R2_D:   begin fpu_req.a = r_d2;  fpu_req.b = big_k; end
            ST_R2_H21: begin fpu_req.a = r_h21; fpu_req.b = small_k; end
            ST_R2_H22: begin fpu_req.a = r_h22; fpu_req.b = small_k; end
            default:   is_op = 1'b0;
        endcase
        fpu_req.start = is_op && !r_wait;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fpu_req.start) begin
                r_wait <= 1'b1;
            end else if (done) begin
                r_wait <= 1'b0;
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    // latch the beat; clear H and the pass counter
                    r_y1   <= i_coord_y;
                    r_h11  <= F_ZERO;
                    r_h21  <= F_ZERO;
                    r_h12  <= F_ZERO;
                    r_h22  <= F_ZERO;
                    r_n    <= 4'd0;
                    r_up   <= 1'b0;
                    if (f_lt(i_scale_one, F_ZERO)) begin
                        r_flag <= FLAG_FULL;
                        r_d1   <= F_ZERO;
                        r_d2   <= F_ZERO;
                        r_x1   <= F_ZERO;
                    end else begin
                        r_flag <= FLAG_IDENT;
                        r_d1   <= i_scale_one;
                        r_d2   <= i_scale_two;
                        r_x1   <= i_coord_x;
                    end
                end
            end
            ST_P2:    if (done) r_p2 <= fpu_rsp.res;
            ST_P1:    if (done) r_p1 <= fpu_rsp.res;
            ST_Q2:    if (done) r_q2 <= fpu_rsp.res;
            ST_Q1:    if (done) r_q1 <= fpu_rsp.res;
            ST_BR: begin
                if (f_lt(f_mag(r_q2), f_mag(r_q1))) begin
                    r_flag <= FLAG_OFF;
                end else if (f_lt(r_q2, F_ZERO)) begin
                    // drop to the zero full-H result
                    r_flag <= FLAG_FULL;
                    r_d1   <= F_ZERO;
                    r_d2   <= F_ZERO;
                    r_x1   <= F_ZERO;
                end else begin
                    r_flag <= FLAG_DIAG;
                end
            end
            ST_H21:   if (done) r_h21 <= fpu_rsp.res;
            ST_H12:   if (done) r_h12 <= fpu_rsp.res;
            ST_OT:    if (done) r_su  <= fpu_rsp.res;
            ST_OSU:   if (done) r_su  <= fpu_rsp.res;
            ST_SUCHK: begin
                if (!f_lt(F_ZERO, r_su)) begin
                    r_flag <= FLAG_FULL;
                    r_h21  <= F_ZERO;
                    r_h12  <= F_ZERO;
                    r_d1   <= F_ZERO;
                    r_d2   <= F_ZERO;
                    r_x1   <= F_ZERO;
                end
            end
            ST_OD_D1: if (done) r_d1  <= fpu_rsp.res;
            ST_OD_D2: if (done) r_d2  <= fpu_rsp.res;
            ST_OD_X1: if (done) r_x1  <= fpu_rsp.res;
            ST_H11:   if (done) r_h11 <= fpu_rsp.res;
            ST_H22:   if (done) r_h22 <= fpu_rsp.res;
            ST_DT:    if (done) r_su  <= fpu_rsp.res;
            ST_DSU:   if (done) r_su  <= fpu_rsp.res;
            ST_DG_T:  if (done) r_p1  <= fpu_rsp.res;  // hold new d1 until old d1 is read
            ST_DG_D2: begin
                if (done) begin
                    r_d2 <= fpu_rsp.res;
                    r_d1 <= r_p1;
                end
            end
            ST_DG_X1: if (done) r_x1 <= fpu_rsp.res;
            ST_R1_CHK, ST_R2_CHK: begin
                if ((r_state == ST_R1_CHK) ? r1_go : r2_go) begin
                    // expand to full H before the pass
                    if (r_flag == FLAG_OFF) begin
                        r_h11 <= F_ONE;
                        r_h22 <= F_ONE;
                    end else if (r_flag == FLAG_DIAG) begin
                        r_h21 <= F_NEG_ONE;
                        r_h12 <= F_ONE;
                    end
                    r_flag <= FLAG_FULL;
                    r_n    <= r_n + 4'd1;
                    r_up   <= (r_state == ST_R1_CHK) ? r1_up : r2_up;
                end else begin
                    r_n <= 4'd0;
                end
            end
            ST_R1_D:   if (done) r_d1  <= fpu_rsp.res;
            ST_R1_X:   if (done) r_x1  <= fpu_rsp.res;
            ST_R1_H11: if (done) r_h11 <= fpu_rsp.res;
            ST_R1_H12: if (done) r_h12 <= fpu_rsp.res;
            ST_R2_D:   if (done) r_d2  <= fpu_rsp.res;
            ST_R2_H21: if (done) r_h21 <= fpu_rsp.res;
            ST_R2_H22: if (done) r_h22 <= fpu_rsp.res;
            default: ;
        endcase
    end

    // ---------------- result beat ----------------
    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = (r_state == ST_DONE);
    assign o_flag_code     = r_flag;
    // implied entries of the flag's form go out as zero
    assign o_h_one_one     = (r_flag == FLAG_OFF)  ? F_ZERO : r_h11;
    assign o_h_two_two     = (r_flag == FLAG_OFF)  ? F_ZERO : r_h22;
    assign o_h_two_one     = (r_flag == FLAG_DIAG) ? F_ZERO : r_h21;
    assign o_h_one_two     = (r_flag == FLAG_DIAG) ? F_ZERO : r_h12;
    assign o_new_scale_one = r_d1;
    assign o_new_scale_two = r_d2;
    assign o_new_coord_x   = r_x1;

    // ---------------- checks ----------------
    a_busy_ends_in_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(o_valid))
        else $error("busy dropped without a result beat");

    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_no_issue_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait && !fpu_rsp.done |=> r_wait)
        else $error("float operation abandoned before completion");

    a_off_diag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_flag_code == FLAG_OFF) |-> (o_h_one_one == F_ZERO)
            && (o_h_two_two == F_ZERO))
        else $error("off-diagonal result carries diagonal entries");

endmodule
